/* src/hbsd_pkg.sv */
package hbsd_pkg;

    localparam int MAX_CODE_LEN  = 16;
    localparam int SYMBOL_COUNT  = 256;
    localparam int COUNT_BITS    = 32;

    localparam int SYM_W         = 8;
    localparam int CODE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int SCOUNT_W      = 32;
    localparam int BYTE_W        = 8;
    localparam int CMD_W         = 2;
    localparam int ACC_W         = MAX_CODE_LEN;
    localparam int IDX_W         = $clog2(SYMBOL_COUNT);
    localparam int BITCNT_W      = $clog2(BYTE_W + 1);

    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 8;
    localparam int OUT_USER_W    = 2;

    localparam int ENTRY_SYM_LO  = 0;
    localparam int CODE_LO       = ENTRY_SYM_LO + SYM_W;
    localparam int LEN_LO        = CODE_LO + CODE_W;
    localparam int SCOUNT_LO     = LEN_LO + LEN_W;
    localparam int BYTE_LO       = SCOUNT_LO + SCOUNT_W;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [ACC_W-1:0] code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done;
        logic             err;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0] len;
    } t_load;

endpackage

/* src/hbsd_ram.sv */
module hbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/hbsd_table.sv */
module hbsd_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hbsd_pkg::t_load              i_load,
    input  logic                         i_rd_en,
    input  logic [hbsd_pkg::IDX_W-1:0]   i_rd_addr,
    input  logic [hbsd_pkg::ACC_W-1:0]   i_acc,
    input  logic [hbsd_pkg::LEN_W-1:0]   i_acc_bits,
    output logic                         o_match
);

    logic [hbsd_pkg::SYMBOL_COUNT-1:0] r_valid;
    logic                              r_rd_valid;
    logic                              n_len_ok;
    logic                              n_in_range;
    logic [hbsd_pkg::CODE_W-1:0]       n_mask;
    hbsd_pkg::t_entry                  n_wr_entry;
    hbsd_pkg::t_entry                  n_rd_entry;

    always_comb begin
        n_len_ok   = (i_load.len >= hbsd_pkg::LEN_W'(1))
                  && (i_load.len <= hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN));
        n_in_range = {1'b0, i_load.sym} < (hbsd_pkg::SYM_W + 1)'(hbsd_pkg::SYMBOL_COUNT);
        for (int i = 0; i < hbsd_pkg::CODE_W; i++) begin
            n_mask[i] = (hbsd_pkg::LEN_W'(i) < i_load.len);
        end
        n_wr_entry.len  = i_load.len;
        n_wr_entry.code = hbsd_pkg::ACC_W'(i_load.code & n_mask);
    end

    hbsd_ram #(
        .WIDTH (hbsd_pkg::ENTRY_W),
        .DEPTH (hbsd_pkg::SYMBOL_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_load.en && n_in_range),
        .i_wr_addr (hbsd_pkg::IDX_W'(i_load.sym)),
        .i_wr_data (n_wr_entry),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (n_rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_load.en && n_in_range) begin
            r_valid[hbsd_pkg::IDX_W'(i_load.sym)] <= n_len_ok;
        end
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_match = r_rd_valid && (n_rd_entry.len == i_acc_bits)
                  && (n_rd_entry.code == i_acc);

endmodule

/* src/hbsd_outreg.sv */
module hbsd_outreg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  hbsd_pkg::t_result                   i_result,
    output logic                                o_can_push,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [hbsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [hbsd_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    logic              r_valid;
    hbsd_pkg::t_result r_result;

    assign o_can_push = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_can_push) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (i_push && o_can_push) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = hbsd_pkg::OUT_DATA_W'(r_result.symbol);
    assign m_axis_tlast  = r_result.last;
    assign m_axis_tuser  = {r_result.err, r_result.done};

endmodule

/* src/huffman_bit_serial_decoder.sv */
// Channel   Direction  Handshake                    Words
// s_axis    in         s_axis_tvalid/s_axis_tready  load entry, start chunk, coded byte
// m_axis    out        m_axis_tvalid/m_axis_tready  decoded symbol or code error
//
// Load, start and unknown words are taken in the idle state. For each bit of a coded byte
// while symbols remain, the sequencer shifts the bit in, scans the code table through the
// single read port, and emits each result found; it then ends the byte and flushes its
// last result.
// Reset is synchronous and clears the table valid bits, the accumulator and the count.
// A stalled output holds the sequencer whenever a held result has to be handed over.
module huffman_bit_serial_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_symbol, code_value, code_length, symbol_count, coded_byte, zero fill
    input  logic [hbsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic [hbsd_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // symbol
    output logic [hbsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    // chunk_complete, code_error
    output logic [hbsd_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state                               r_state, n_state;
    logic [hbsd_pkg::BYTE_W-1:0]          r_byte, n_byte;
    logic [hbsd_pkg::BITCNT_W-1:0]        r_bits_left, n_bits_left;
    logic [hbsd_pkg::ACC_W-1:0]           r_acc, n_acc;
    logic [hbsd_pkg::LEN_W-1:0]           r_nbits, n_nbits;
    logic [hbsd_pkg::COUNT_BITS-1:0]      r_left, n_left;
    logic [hbsd_pkg::IDX_W:0]             r_addr, n_addr;
    logic                                 r_chk_v, n_chk_v;
    logic [hbsd_pkg::IDX_W-1:0]           r_chk_idx, n_chk_idx;
    hbsd_pkg::t_result                    r_new, n_new;
    hbsd_pkg::t_result                    r_pend, n_pend;
    logic                                 r_pend_v, n_pend_v;

    logic                                 n_accept;
    logic                                 n_rd_en;
    logic                                 n_match;
    logic                                 n_push;
    logic                                 n_can_push;
    hbsd_pkg::t_result                    n_push_result;
    hbsd_pkg::t_load                      n_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign n_accept      = s_axis_tvalid && s_axis_tready;
    assign n_rd_en       = (r_state == S_SCAN) && !r_addr[hbsd_pkg::IDX_W];

    always_comb begin
        n_load.en   = n_accept && (s_axis_tuser == hbsd_pkg::CMD_LOAD);
        n_load.sym  = s_axis_tdata[hbsd_pkg::CODE_LO-1:hbsd_pkg::ENTRY_SYM_LO];
        n_load.code = s_axis_tdata[hbsd_pkg::LEN_LO-1:hbsd_pkg::CODE_LO];
        n_load.len  = s_axis_tdata[hbsd_pkg::SCOUNT_LO-1:hbsd_pkg::LEN_LO];
    end

    hbsd_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (n_load),
        .i_rd_en    (n_rd_en),
        .i_rd_addr  (r_addr[hbsd_pkg::IDX_W-1:0]),
        .i_acc      (r_acc),
        .i_acc_bits (r_nbits),
        .o_match    (n_match)
    );

    hbsd_outreg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (n_push),
        .i_result      (n_push_result),
        .o_can_push    (n_can_push),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb begin
        n_state       = r_state;
        n_byte        = r_byte;
        n_bits_left   = r_bits_left;
        n_acc         = r_acc;
        n_nbits       = r_nbits;
        n_left        = r_left;
        n_addr        = r_addr;
        n_chk_v       = 1'b0;
        n_chk_idx     = r_addr[hbsd_pkg::IDX_W-1:0];
        n_new         = r_new;
        n_pend        = r_pend;
        n_pend_v      = r_pend_v;
        n_push        = 1'b0;
        n_push_result = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (n_accept) begin
                    case (s_axis_tuser)
                        hbsd_pkg::CMD_START: begin
                            n_left  = hbsd_pkg::COUNT_BITS'(
                                s_axis_tdata[hbsd_pkg::BYTE_LO-1:hbsd_pkg::SCOUNT_LO]);
                            n_acc   = '0;
                            n_nbits = '0;
                        end
                        hbsd_pkg::CMD_BYTE: begin
                            n_byte      = s_axis_tdata[hbsd_pkg::BYTE_LO +: hbsd_pkg::BYTE_W];
                            n_bits_left = hbsd_pkg::BITCNT_W'(hbsd_pkg::BYTE_W);
                            n_state     = S_BIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BIT: begin
                if (r_bits_left == '0 || r_left == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_acc       = {r_acc[hbsd_pkg::ACC_W-2:0], r_byte[hbsd_pkg::BYTE_W-1]};
                    n_byte      = {r_byte[hbsd_pkg::BYTE_W-2:0], 1'b0};
                    n_bits_left = r_bits_left - hbsd_pkg::BITCNT_W'(1);
                    n_nbits     = r_nbits + hbsd_pkg::LEN_W'(1);
                    n_addr      = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                n_chk_v = n_rd_en;
                if (n_rd_en) begin
                    n_addr = r_addr + (hbsd_pkg::IDX_W + 1)'(1);
                end
                if (r_chk_v && n_match) begin
                    n_chk_v       = 1'b0;
                    n_left        = r_left - hbsd_pkg::COUNT_BITS'(1);
                    n_new.symbol  = hbsd_pkg::SYM_W'(r_chk_idx);
                    n_new.last    = 1'b0;
                    n_new.done    = (r_left == hbsd_pkg::COUNT_BITS'(1));
                    n_new.err     = 1'b0;
                    n_acc         = '0;
                    n_nbits       = '0;
                    n_state       = S_EMIT;
                end else if (r_chk_v
                             && r_chk_idx == hbsd_pkg::IDX_W'(hbsd_pkg::SYMBOL_COUNT - 1)) begin
                    n_chk_v = 1'b0;
                    if (r_nbits >= hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN)) begin
                        n_new.symbol = '0;
                        n_new.last   = 1'b0;
                        n_new.done   = 1'b0;
                        n_new.err    = 1'b1;
                        n_acc        = '0;
                        n_nbits      = '0;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_EMIT: begin
                if (!r_pend_v) begin
                    n_pend   = r_new;
                    n_pend_v = 1'b1;
                    n_state  = S_BIT;
                end else if (n_can_push) begin
                    n_push        = 1'b1;
                    n_push_result = r_pend;
                    n_pend        = r_new;
                    n_state       = S_BIT;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (n_can_push) begin
                    n_push             = 1'b1;
                    n_push_result      = r_pend;
                    n_push_result.last = 1'b1;
                    n_pend_v           = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_nbits  <= '0;
            r_left   <= '0;
            r_chk_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_nbits  <= n_nbits;
            r_left   <= n_left;
            r_chk_v  <= n_chk_v;
            r_pend_v <= n_pend_v;
        end
        r_byte      <= n_byte;
        r_bits_left <= n_bits_left;
        r_addr      <= n_addr;
        r_chk_idx   <= n_chk_idx;
        r_new       <= n_new;
        r_pend      <= n_pend;
    end

endmodule

/* test/huffman_bit_serial_decoder_check.sv */
`timescale 1ns / 100ps

module huffman_bit_serial_decoder_check
    import hbsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    // entry_symbol, code_value, code_length, symbol_count, coded_byte, zero fill
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    // command
    input  logic [CMD_W-1:0]      i_in_tuser,
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    // symbol
    input  logic [OUT_DATA_W-1:0] i_out_tdata,
    input  logic                  i_out_tlast,
    // chunk_complete, code_error
    input  logic [OUT_USER_W-1:0] i_out_tuser,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_symbol_count,
    output int                    o_error_count
);

    logic [CODE_W-1:0]     code_word [SYMBOL_COUNT];
    logic [LEN_W-1:0]      code_len  [SYMBOL_COUNT];
    logic                  code_ok   [SYMBOL_COUNT];
    logic [ACC_W-1:0]      shift_bits;
    int unsigned           shift_count;
    logic [COUNT_BITS-1:0] remaining;
    t_result               expected_q [$];
    t_result               got;
    t_result               want;
    int                    fails;
    int                    symbols_seen;
    int                    errors_seen;

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endtask

    task automatic predict_word(input logic [CMD_W-1:0] cmd,
                                input logic [IN_DATA_W-1:0] fields);
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic              ok;
        int                hit;
        int                first;
        t_result           item;
        sym  = fields[ENTRY_SYM_LO +: SYM_W];
        len  = fields[LEN_LO +: LEN_W];
        data = fields[BYTE_LO +: BYTE_W];
        case (cmd)
            CMD_LOAD: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    ok = (len >= 1) && (int'(len) <= MAX_CODE_LEN);
                    code_ok[sym]   = ok;
                    code_len[sym]  = len;
                    code_word[sym] = ok ? (fields[CODE_LO +: CODE_W]
                                           & CODE_W'((32'd1 << len) - 32'd1)) : '0;
                end
            end
            CMD_START: begin
                remaining   = COUNT_BITS'(fields[SCOUNT_LO +: SCOUNT_W]);
                shift_bits  = '0;
                shift_count = 0;
            end
            CMD_BYTE: begin
                first = expected_q.size();
                for (int k = 0; k < BYTE_W && remaining != '0; k++) begin
                    shift_count++;
                    shift_bits = {shift_bits[ACC_W-2:0], data[BYTE_W-1-k]};
                    hit = -1;
                    for (int s = 0; s < SYMBOL_COUNT && hit < 0; s++) begin
                        if (code_ok[s] && code_len[s] == shift_count
                            && code_word[s] == shift_bits) begin
                            hit = s;
                        end
                    end
                    if (hit >= 0) begin
                        remaining--;
                        item = '{symbol: SYM_W'(hit), last: 1'b0,
                                 done: (remaining == '0), err: 1'b0};
                        expected_q.insert(expected_q.size(), item);
                        shift_bits  = '0;
                        shift_count = 0;
                    end else if (shift_count >= MAX_CODE_LEN) begin
                        item = '{symbol: '0, last: 1'b0, done: 1'b0, err: 1'b1};
                        expected_q.insert(expected_q.size(), item);
                        shift_bits  = '0;
                        shift_count = 0;
                    end
                end
                if (expected_q.size() > first) begin
                    item = expected_q.pop_back();
                    item.last = 1'b1;
                    expected_q.insert(expected_q.size(), item);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SYMBOL_COUNT; s++) begin
                code_ok[s] = 1'b0;
            end
            shift_bits  = '0;
            shift_count = 0;
            remaining   = '0;
            expected_q.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                predict_word(i_in_tuser, i_in_tdata);
            end
            if (i_out_tvalid && i_out_tready) begin
                got = '{symbol: i_out_tdata, last: i_out_tlast, done: i_out_tuser[0],
                        err: i_out_tuser[1]};
                if (got.err === 1'b1) begin
                    errors_seen++;
                end else begin
                    symbols_seen++;
                end
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, got symbol %0d last %0d "
                             , $time, got.symbol, got.last,
                             "complete %0d error %0d", got.done, got.err);
                end else begin
                    want = expected_q.pop_front();
                    check_field("symbol", want.symbol, got.symbol);
                    check_field("last_of_run", want.last, got.last);
                    check_field("chunk_complete", want.done, got.done);
                    check_field("code_error", want.err, got.err);
                end
            end
        end
        o_fail_count   <= fails + expected_q.size();
        o_pending      <= expected_q.size();
        o_symbol_count <= symbols_seen;
        o_error_count  <= errors_seen;
    end

endmodule

/* test/huffman_bit_serial_decoder_test.sv */
`timescale 1ns / 100ps

module huffman_bit_serial_decoder_test;
    import hbsd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int ITEM_TARGET  = 480;
    localparam int SET_MAX      = 32;
    localparam int DRAIN_CYCLES = BYTE_W * (SYMBOL_COUNT + 4) + 100;
    localparam int CYCLE_LIMIT  = 5_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int          fail_count;
    int          pending;
    int          decoded;
    int          code_errors;
    int unsigned cycle_count;
    int unsigned sent_items;
    int unsigned sets_built;
    int unsigned results_taken;
    int unsigned results_noted;
    int unsigned ready_hold;
    bit          calm;

    logic [SYM_W-1:0]  set_sym  [SET_MAX];
    logic [CODE_W-1:0] set_code [SET_MAX];
    logic [LEN_W-1:0]  set_len  [SET_MAX];
    int                set_size;

    huffman_bit_serial_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    huffman_bit_serial_decoder_check checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_tvalid    (s_axis_tvalid),
        .i_in_tready    (s_axis_tready),
        .i_in_tdata     (s_axis_tdata),
        .i_in_tuser     (s_axis_tuser),
        .i_out_tvalid   (m_axis_tvalid),
        .i_out_tready   (m_axis_tready),
        .i_out_tdata    (m_axis_tdata),
        .i_out_tlast    (m_axis_tlast),
        .i_out_tuser    (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_symbol_count (decoded),
        .o_error_count  (code_errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            results_taken <= results_taken + 1;
        end
    end

    always @(negedge i_clk) begin
        if (results_noted != results_taken) begin
            results_noted = results_taken;
            ready_hold = calm ? 0 : $urandom_range(0, 5);
        end
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(
        input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
        input logic [LEN_W-1:0] len, input logic [SCOUNT_W-1:0] count,
        input logic [BYTE_W-1:0] data);
        logic [IN_DATA_W-1:0] w;
        w = '0;
        w[ENTRY_SYM_LO +: SYM_W] = sym;
        w[CODE_LO +: CODE_W]     = code;
        w[LEN_LO +: LEN_W]       = len;
        w[SCOUNT_LO +: SCOUNT_W] = count;
        w[BYTE_LO +: BYTE_W]     = data;
        return w;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_fields();
        return pack_fields(SYM_W'($urandom()), CODE_W'($urandom()), LEN_W'($urandom()),
                           $urandom(), BYTE_W'($urandom()));
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [IN_DATA_W-1:0] fields);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fields;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (cmd != CMD_NONE) begin
            sent_items++;
        end
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len);
        send_word(CMD_LOAD, pack_fields(sym, code, len, $urandom(), BYTE_W'($urandom())));
    endtask

    task automatic start_chunk(input logic [SCOUNT_W-1:0] count);
        send_word(CMD_START, pack_fields(SYM_W'($urandom()), CODE_W'($urandom()),
                                         LEN_W'($urandom()), count, BYTE_W'($urandom())));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send_word(CMD_BYTE, pack_fields(SYM_W'($urandom()), CODE_W'($urandom()),
                                        LEN_W'($urandom()), $urandom(), data));
    endtask

    // The previous table is retired with bad lengths, then a fresh prefix code is grown by
    // splitting leaves, sometimes with one leaf removed so that some bit patterns never match.
    task automatic build_code_set();
        int lens [SET_MAX];
        int leaves;
        int target;
        int depth_cap;
        int pick;
        int tmp;
        int code;
        bit used [SYMBOL_COUNT];
        for (int i = 0; i < set_size; i++) begin
            load_entry(set_sym[i], CODE_W'($urandom()),
                       ($urandom_range(0, 1) != 0) ? LEN_W'(0)
                           : LEN_W'($urandom_range(MAX_CODE_LEN + 1, (1 << LEN_W) - 1)));
        end
        leaves    = 2;
        lens[0]   = 1;
        lens[1]   = 1;
        target    = $urandom_range(2, 24);
        depth_cap = $urandom_range(3, MAX_CODE_LEN);
        for (int tries = 0; tries < 200 && leaves < target; tries++) begin
            pick = $urandom_range(0, leaves - 1);
            if ($urandom_range(0, 1) != 0) begin
                for (int i = 0; i < leaves; i++) begin
                    if (lens[i] > lens[pick]) pick = i;
                end
            end
            if (lens[pick] < depth_cap) begin
                lens[pick]++;
                lens[leaves] = lens[pick];
                leaves++;
            end
        end
        if (leaves > 2 && $urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, leaves - 1);
            leaves--;
            lens[pick] = lens[leaves];
        end
        for (int i = 1; i < leaves; i++) begin
            for (int j = i; j > 0 && lens[j-1] > lens[j]; j--) begin
                tmp       = lens[j];
                lens[j]   = lens[j-1];
                lens[j-1] = tmp;
            end
        end
        code = 0;
        for (int i = 0; i < leaves; i++) begin
            if (i > 0) code = (code + 1) << (lens[i] - lens[i-1]);
            do pick = $urandom_range(0, SYMBOL_COUNT - 1); while (used[pick]);
            used[pick]  = 1'b1;
            set_sym[i]  = SYM_W'(pick);
            set_code[i] = CODE_W'(code);
            set_len[i]  = LEN_W'(lens[i]);
            load_entry(set_sym[i],
                       ($urandom_range(0, 2) == 0) ? CODE_W'(code | ($urandom() << lens[i]))
                                                   : CODE_W'(code),
                       set_len[i]);
        end
        set_size = leaves;
        sets_built++;
    endtask

    // A damaged chunk has flipped bits, may claim more symbols than it holds, and may
    // be cut short before the next start.
    task automatic send_chunk(input bit damaged);
        bit                stream [$];
        int                symbols;
        int                k;
        bit                spare;
        logic [BYTE_W-1:0] data;
        symbols = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < symbols; i++) begin
            k = $urandom_range(0, set_size - 1);
            for (int j = int'(set_len[k]) - 1; j >= 0; j--) begin
                stream.insert(stream.size(), set_code[k][j]);
            end
        end
        if (damaged) begin
            repeat ($urandom_range(1, 3)) begin
                k = $urandom_range(0, stream.size() - 1);
                stream[k] = !stream[k];
            end
        end
        while (stream.size() % BYTE_W != 0) begin
            stream.insert(stream.size(), 1'($urandom_range(0, 1)));
        end
        spare = ($urandom_range(0, 3) == 0);
        start_chunk((damaged && $urandom_range(0, 1) != 0)
                        ? SCOUNT_W'(symbols + $urandom_range(1, 3)) : SCOUNT_W'(symbols));
        while (stream.size() > 0) begin
            for (int j = 0; j < BYTE_W; j++) begin
                data[BYTE_W-1-j] = stream.pop_front();
            end
            send_byte(data);
            if (damaged && stream.size() > 0 && $urandom_range(0, 3) == 0) begin
                stream.delete();
            end
        end
        if (spare) begin
            send_byte(BYTE_W'($urandom()));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Padding is ignored when no chunk is open.
        start_chunk('0);
        send_byte(8'hFF);
        // Code bits above the length are masked, and the lower symbol wins a shared code.
        load_entry(8'd0, 16'hFFFF, 5'd1);
        load_entry(8'd255, 16'h0001, 5'd1);
        load_entry(8'd7, 16'h0000, 5'd1);
        load_entry(8'd9, 16'h0003, 5'd0);
        load_entry(8'd10, 16'h0003, 5'd31);
        load_entry(8'd11, 16'h0000, 5'd17);
        send_word(CMD_NONE, random_fields());
        start_chunk('1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        // The chunk completes part way through a word and the rest is padding.
        start_chunk(32'd3);
        send_byte(8'h0F);
        send_byte(8'h55);
        load_entry(8'd0, 16'h0000, 5'd0);
        load_entry(8'd255, 16'h0000, 5'd0);
        load_entry(8'd7, 16'h0000, 5'd0);
        // A full-length code, then sixteen bits that match nothing.
        load_entry(8'd1, 16'hFFFF, 5'd16);
        start_chunk(32'd2);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);

        set_size   = 1;
        set_sym[0] = 8'd1;
        while (sent_items < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 3))
                            0: load_entry(SYM_W'($urandom()), CODE_W'($urandom()),
                                          LEN_W'($urandom()));
                            1: start_chunk(($urandom_range(0, 1) != 0) ? $urandom()
                                                                       : $urandom_range(0, 6));
                            2: send_byte(BYTE_W'($urandom()));
                            default: send_word(CMD_NONE, random_fields());
                        endcase
                    end
                end
                default: begin
                    if (set_size < 2 || $urandom_range(0, 3) == 0) build_code_set();
                    send_chunk($urandom_range(0, 4) == 0);
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words over %0d code tables, with short and long chunks, padding,",
                 sent_items, sets_built);
        $display("damaged streams and noise; %0d symbols decoded and %0d code errors seen.",
                 decoded, code_errors);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
src/hbsd_pkg.sv
src/hbsd_ram.sv
src/hbsd_table.sv
src/hbsd_outreg.sv
src/huffman_bit_serial_decoder.sv
test/huffman_bit_serial_decoder_check.sv
test/huffman_bit_serial_decoder_test.sv
